FILE: sv/adcscan_pkg.sv
package adcscan_pkg;

    localparam int CHANNELS_DEFAULT = 8;

    // widths of the stream and configuration ports
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // the enable mask and the register file cover eight slots at most
    localparam int MASK_SLOTS = 8;

    localparam logic [7:0] CNT_ACCUM_LIMIT = 8'h10;
    localparam logic [7:0] CNT_STOPPED = 8'hFF;
    localparam logic [7:0] SLOT_IDLE = 8'hFF;
    localparam logic [14:0] ROUND_ADD = 15'd8;
    localparam int AVG_SHIFT = 4;
    localparam logic [9:0] READ_MAX = 10'h3FF;

    localparam logic [7:0] SETTLE_RESET = 8'd89;
    localparam logic [7:0] RELOAD_RESET = 8'd100;

    typedef enum logic [1:0] {
        MODE_CONV = 2'd0,
        MODE_POLL = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MASK   = 2'd0,
        REG_SETTLE = 2'd1,
        REG_RELOAD = 2'd2
    } cfg_reg_t;

endpackage

FILE: sv/adc_scan_oversample_change_detect_top.sv
// ADC scan sequencer with 16-fold oversampling and change detection. One event
// is taken every clock cycle when the result side keeps up; each event passes an
// input register and then a result register, and every event yields exactly one
// result. Events are kinds in s_axis_tuser: conversion done (steps the
// settle/accumulate counter of the current slot), poll tick (per-channel timeout,
// scan restart, change report) and read (rounded average of the reported sum,
// saturated to 10 bits). Per-slot sums and timeouts sit in flip-flops cleared by
// reset; configuration writes are taken every cycle and are meant to happen while
// no event is in flight.
module adc_scan_oversample_change_detect_top #(
    parameter int CHANNELS = adcscan_pkg::CHANNELS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample[9:0], channel[12:10], sleep[13], zero[15:14]
    input  logic [adcscan_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // mode[1:0]
    input  logic [adcscan_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // select_valid[0], select_slot[3:1], select_ground[4], adc_run[5],
    // changed[6], read_value[16:7], zero[23:17]
    output logic [adcscan_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [adcscan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adcscan_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adcscan_pkg::*;

    localparam int NSLOT = (CHANNELS < MASK_SLOTS) ? CHANNELS : MASK_SLOTS;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic [9:0]  in_sample_reg;
    logic [2:0]  in_channel_reg;
    logic        in_sleep_reg;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;

    // configuration
    logic [7:0] mask_reg, mask_next;
    logic [7:0] settle_reg, settle_next;
    logic [7:0] reload_reg, reload_next;

    // scan state
    logic [7:0]  scan_slot_reg, scan_slot_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] sum_reg, sum_next;
    logic        run_reg, run_next;
    logic [13:0] latest_reg   [NSLOT];
    logic [13:0] latest_next  [NSLOT];
    logic [13:0] reported_reg [NSLOT];
    logic [13:0] reported_next[NSLOT];
    logic [7:0]  timeout_reg  [NSLOT];
    logic [7:0]  timeout_next [NSLOT];

    logic        adv;
    logic        in_take;
    logic        ch_ok;
    logic [13:0] sel_latest;
    logic [13:0] sel_reported;
    logic [7:0]  sel_timeout;
    logic [15:0] sum_add;
    logic        slot_en;
    logic [14:0] rd_sum;
    logic [14:0] rd_shift;
    logic [9:0]  rd_val;
    logic [7:0]  rising;

    logic        r_sel_valid;
    logic [2:0]  r_sel_slot;
    logic        r_sel_gnd;
    logic        r_changed;
    logic [9:0]  r_read;

    assign adv = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign in_take = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    assign ch_ok = {1'b0, in_channel_reg} < 4'(NSLOT);
    assign sum_add = sum_reg + 16'(in_sample_reg);
    assign slot_en = (scan_slot_reg < 8'(MASK_SLOTS)) && mask_reg[scan_slot_reg[2:0]];

    always_comb begin
        sel_latest = '0;
        sel_reported = '0;
        sel_timeout = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (in_channel_reg == 3'(i)) begin
                sel_latest = latest_reg[i];
                sel_reported = reported_reg[i];
                sel_timeout = timeout_reg[i];
            end
        end
    end

    assign rd_sum = {1'b0, sel_reported} + ROUND_ADD;
    assign rd_shift = rd_sum >> AVG_SHIFT;
    assign rd_val = (rd_shift > 15'(READ_MAX)) ? READ_MAX : rd_shift[9:0];

    always_comb begin
        scan_slot_next = scan_slot_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        run_next = run_reg;
        latest_next = latest_reg;
        reported_next = reported_reg;
        timeout_next = timeout_reg;
        mask_next = mask_reg;
        settle_next = settle_reg;
        reload_next = reload_reg;
        r_sel_valid = 1'b0;
        r_sel_slot = '0;
        r_sel_gnd = 1'b0;
        r_changed = 1'b0;
        r_read = '0;

        if (adv) begin
            unique case (mode_t'(in_mode_reg))
                MODE_CONV: begin
                    if (run_reg) begin
                        if (scan_slot_reg >= 8'(CHANNELS)) begin
                            // past the last slot: stop and ground the mux
                            run_next = 1'b0;
                            r_sel_valid = 1'b1;
                            r_sel_gnd = 1'b1;
                            scan_slot_next = '0;
                            cnt_next = CNT_STOPPED;
                        end else if (cnt_reg < CNT_ACCUM_LIMIT) begin
                            sum_next = sum_add;
                            if (cnt_reg == '0) begin
                                for (int i = 0; i < NSLOT; i++) begin
                                    if (scan_slot_reg == 8'(i)) begin
                                        latest_next[i] = sum_add[13:0];
                                    end
                                end
                                scan_slot_next = scan_slot_reg + 8'd1;
                                // reload with settle, then the usual step down
                                cnt_next = settle_reg;
                            end else begin
                                cnt_next = cnt_reg - 8'd1;
                            end
                        end else begin
                            if (cnt_reg == settle_reg) begin
                                r_sel_valid = 1'b1;
                                r_sel_slot = scan_slot_reg[2:0];
                                r_sel_gnd = !slot_en;
                                sum_next = '0;
                            end
                            cnt_next = cnt_reg - 8'd1;
                        end
                    end
                end
                MODE_POLL: begin
                    if (ch_ok) begin
                        for (int i = 0; i < NSLOT; i++) begin
                            if (in_channel_reg == 3'(i)) begin
                                if (in_sleep_reg || sel_timeout == '0) begin
                                    timeout_next[i] = reload_reg;
                                end else begin
                                    timeout_next[i] = sel_timeout - 8'd1;
                                end
                                if (!in_sleep_reg && sel_timeout == '0
                                        && sel_reported != sel_latest) begin
                                    reported_next[i] = sel_latest;
                                end
                            end
                        end
                        if (in_sleep_reg) begin
                            scan_slot_next = SLOT_IDLE;
                        end else if (sel_timeout == '0) begin
                            if (!run_reg) begin
                                scan_slot_next = '0;
                                run_next = 1'b1;
                            end
                            r_changed = (sel_reported != sel_latest);
                        end
                    end
                end
                MODE_READ: begin
                    if (ch_ok) begin
                        r_read = rd_val;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MASK: begin
                    mask_next = cfg_data;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (rising[i]) begin
                            timeout_next[i] = reload_reg;
                            latest_next[i] = '0;
                            reported_next[i] = '0;
                        end
                    end
                end
                REG_SETTLE: settle_next = cfg_data;
                REG_RELOAD: reload_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign rising = cfg_data & ~mask_reg;

    always_comb begin
        out_data_next = {7'b0, r_read, r_changed, run_next, r_sel_gnd, r_sel_slot,
                         r_sel_valid};
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg <= '0;
            settle_reg <= SETTLE_RESET;
            reload_reg <= RELOAD_RESET;
            scan_slot_reg <= SLOT_IDLE;
            cnt_reg <= '0;
            sum_reg <= '0;
            run_reg <= 1'b0;
            for (int i = 0; i < NSLOT; i++) begin
                latest_reg[i] <= '0;
                reported_reg[i] <= '0;
                timeout_reg[i] <= '0;
            end
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            mask_reg <= mask_next;
            settle_reg <= settle_next;
            reload_reg <= reload_next;
            scan_slot_reg <= scan_slot_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            run_reg <= run_next;
            latest_reg <= latest_next;
            reported_reg <= reported_next;
            timeout_reg <= timeout_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mode_reg <= s_axis_tuser;
            in_sample_reg <= s_axis_tdata[9:0];
            in_channel_reg <= s_axis_tdata[12:10];
            in_sleep_reg <= s_axis_tdata[13];
        end
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: sv/adcscan_checker.sv
module adcscan_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [adcscan_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import adcscan_pkg::*;

    // no result left over from before reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // ground or a slot number only come with a mux switch
    a_select: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> !m_axis_tdata[4] && m_axis_tdata[3:1] == 3'd0)
        else $error("mux fields set without select_valid");

    // a result answers one kind of event only
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[6])
            && !(m_axis_tdata[6] && m_axis_tdata[16:7] != 10'd0)
            && !(m_axis_tdata[0] && m_axis_tdata[16:7] != 10'd0))
        else $error("fields of different event kinds mixed");

endmodule

bind adc_scan_oversample_change_detect_top adcscan_checker u_adcscan_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
